@@ rtl/core/cslc_pkg.sv @@
// Shared types, constants and the log10 chart table of the soil layer classifier.
package cslc_pkg;

    localparam int COUNT_WIDTH    = 16;
    localparam int LOG_TABLE_BITS = 10;
    localparam int LOG_SHIFT      = 14 - LOG_TABLE_BITS;

    localparam int DEPTH_W = 18;
    localparam int QC_W    = 17;
    localparam int FR_W    = 15;
    localparam int CFG_W   = 14;
    localparam int LVL_W   = DEPTH_W + 1;
    localparam int FC_W    = 10;
    localparam int Y_W     = LOG_TABLE_BITS + 3;
    localparam int CMP_W   = LOG_TABLE_BITS + 12;

    localparam int DATA_W = 32;
    localparam int ADDR_W = 4;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam int FC_MAX         = 1000;
    localparam int FC_MID         = 500;
    localparam int FC_CLAY_LIMIT  = 400;
    localparam int CHART_SCALE    = 250;
    localparam int LOG_TABLE_SIZE = 100;
    localparam int LOG_IDX_W      = $clog2(LOG_TABLE_SIZE);

    localparam logic [CFG_W-1:0] MIN_LAYER_RESET  = CFG_W'(20);
    localparam logic [CFG_W-1:0] PEAT_LIMIT_RESET = CFG_W'(10000);

    localparam logic [14:0] LOG10_Q14 [LOG_TABLE_SIZE] = '{
        15'd0,     15'd0,     15'd4932,  15'd7817,  15'd9864,
        15'd11452, 15'd12749, 15'd13846, 15'd14796, 15'd15634,
        15'd16384, 15'd17062, 15'd17681, 15'd18251, 15'd18778,
        15'd19269, 15'd19728, 15'd20160, 15'd20566, 15'd20951,
        15'd21316, 15'd21663, 15'd21994, 15'd22311, 15'd22613,
        15'd22904, 15'd23183, 15'd23451, 15'd23710, 15'd23960,
        15'd24201, 15'd24434, 15'd24660, 15'd24879, 15'd25092,
        15'd25298, 15'd25498, 15'd25693, 15'd25883, 15'd26068,
        15'd26248, 15'd26424, 15'd26595, 15'd26763, 15'd26926,
        15'd27086, 15'd27243, 15'd27396, 15'd27545, 15'd27692,
        15'd27836, 15'd27977, 15'd28115, 15'd28251, 15'd28384,
        15'd28514, 15'd28642, 15'd28768, 15'd28892, 15'd29014,
        15'd29133, 15'd29251, 15'd29367, 15'd29480, 15'd29592,
        15'd29703, 15'd29811, 15'd29918, 15'd30024, 15'd30128,
        15'd30230, 15'd30331, 15'd30431, 15'd30529, 15'd30625,
        15'd30721, 15'd30815, 15'd30908, 15'd31000, 15'd31091,
        15'd31180, 15'd31269, 15'd31356, 15'd31442, 15'd31527,
        15'd31612, 15'd31695, 15'd31777, 15'd31858, 15'd31939,
        15'd32018, 15'd32097, 15'd32175, 15'd32252, 15'd32328,
        15'd32403, 15'd32478, 15'd32551, 15'd32624, 15'd32696
    };

    localparam logic signed [Y_W-1:0] Y_ONE = Y_W'(1 << LOG_TABLE_BITS);
    localparam logic signed [Y_W-1:0] Y_TWO = Y_W'(2 << LOG_TABLE_BITS);
    localparam int CHART_OFFSET = CHART_SCALE * (int'(LOG10_Q14[2]) >> LOG_SHIFT);

    typedef enum logic [1:0] {
        KIND_EXC  = 2'd0,
        KIND_SAND = 2'd1,
        KIND_CLAY = 2'd2,
        KIND_PEAT = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        REG_GROUND_TOP       = 2'd0,
        REG_EXCAVATED_DEPTH  = 2'd1,
        REG_MIN_LAYER_HEIGHT = 2'd2,
        REG_PEAT_RATIO_LIMIT = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [DEPTH_W-1:0] ground_top;
        logic [CFG_W-1:0]   excavated_depth;
        logic [CFG_W-1:0]   min_layer_height;
        logic [CFG_W-1:0]   peat_ratio_limit;
    } t_cfg;

    typedef struct packed {
        t_kind              kind;
        logic [DEPTH_W-1:0] top;
        logic [DEPTH_W-1:0] bottom;
        logic               final_layer;
    } t_layer;

    typedef struct packed {
        logic [1:0] count;
        t_layer     first;
        t_layer     second;
    } t_push;

    // Fixed-point log10 of the cone resistance, scaled by 2^LOG_TABLE_BITS.
    function automatic logic signed [Y_W-1:0] log_y(input logic [QC_W-1:0] q);
        logic [14:0] t;
        t = LOG10_Q14[q[LOG_IDX_W-1:0]];
        if (q == '0) begin
            return -Y_ONE;
        end
        if (q >= QC_W'(LOG_TABLE_SIZE)) begin
            return Y_TWO;
        end
        return Y_W'(t >> LOG_SHIFT);
    endfunction

endpackage

@@ rtl/core/cslc_if.sv @@
// Sample and layer channel interfaces of the soil layer classifier.
interface cslc_smp_if import cslc_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [DEPTH_W-1:0] depth;
    logic        [QC_W-1:0]    cone_resistance;
    logic signed [FR_W-1:0]    friction_ratio;
    logic                      last_sample;

    modport source (output valid, depth, cone_resistance, friction_ratio, last_sample,
                    input ready);
    modport sink (input valid, depth, cone_resistance, friction_ratio, last_sample,
                  output ready);
endinterface

interface cslc_lyr_if import cslc_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic        [1:0]         layer_kind;
    logic signed [DEPTH_W-1:0] layer_top;
    logic signed [DEPTH_W-1:0] layer_bottom;
    logic                      final_layer;

    modport source (output valid, layer_kind, layer_top, layer_bottom, final_layer,
                    input ready);
    modport sink (input valid, layer_kind, layer_top, layer_bottom, final_layer,
                  output ready);
endinterface

@@ rtl/core/cpt_soil_layer_classifier.sv @@
// Top level of the cone-test soil layer classifier.
//
// Samples of one cone test enter on i_smp, one transfer per sample, with falling
// depth; last_sample closes the test. Each sample is typed as sand, clay or peat
// from the friction ratio and the log of cone resistance, or as excavated at or
// above the excavated level. Closed depth windows form layers, which leave on o_lyr,
// one layer per transfer, with final_layer set on the last layer of a test.
// The APB port sets ground_top, excavated_depth, min_layer_height and
// peat_ratio_limit; the user must write it only while the block is idle, and the
// block itself does not enforce this. A sample is held in an input register and
// is processed once the result queue has room; its layers then enter the queue.
// One sample is accepted every cycle while the four-entry result queue keeps two
// free slots; a sample yields at most two layers and o_lyr drains one per cycle,
// so the queue drain rate sets the sustained rate when many layers close.
// When the receiver stalls, the queue fills and i_smp.ready drops until room returns.
// Reset clears the queue, the test state and the registers to their reset values.
module cpt_soil_layer_classifier import cslc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    cslc_smp_if.sink   i_smp,
    cslc_lyr_if.source o_lyr
);

    t_cfg  w_cfg;
    t_push w_push;
    logic  w_room;

    cslc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    cslc_layer u_layer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_room  (w_room),
        .o_push  (w_push),
        .i_smp   (i_smp)
    );

    cslc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_room  (w_room),
        .o_lyr   (o_lyr)
    );

endmodule

@@ rtl/core/cslc_classify.sv @@
// Soil type chart on clamped friction ratio and fixed-point log10 of cone resistance.
module cslc_classify import cslc_pkg::*; (
    input  logic        [QC_W-1:0]  i_cone_resistance,
    input  logic signed [FR_W-1:0]  i_friction_ratio,
    input  logic        [CFG_W-1:0] i_peat_ratio_limit,
    output t_kind                   o_kind
);

    localparam logic signed [CMP_W-1:0] SCALE_S  = CMP_W'(CHART_SCALE);
    localparam logic signed [CMP_W-1:0] MID_S    = CMP_W'(FC_MID);
    localparam logic signed [CMP_W-1:0] OFFSET_S = CMP_W'(CHART_OFFSET);

    logic        [FC_W-1:0]  w_fc;
    logic signed [Y_W-1:0]   w_y;
    logic signed [CMP_W-1:0] w_fc_ext;
    logic signed [CMP_W-1:0] w_y_scaled;
    logic signed [CMP_W-1:0] w_lo_line;
    logic signed [CMP_W-1:0] w_hi_line;

    always_comb begin
        if (i_friction_ratio < 0) begin
            w_fc = '0;
        end else if (i_friction_ratio > FR_W'(FC_MAX)) begin
            w_fc = FC_W'(FC_MAX);
        end else begin
            w_fc = i_friction_ratio[FC_W-1:0];
        end
    end

    assign w_y        = log_y(i_cone_resistance);
    assign w_fc_ext   = $signed(CMP_W'(w_fc));
    assign w_y_scaled = SCALE_S * CMP_W'(w_y);
    assign w_lo_line  = (w_fc_ext - MID_S) <<< LOG_TABLE_BITS;
    assign w_hi_line  = (w_fc_ext <<< LOG_TABLE_BITS) - OFFSET_S;

    always_comb begin
        if (w_y_scaled <= w_lo_line) begin
            o_kind = (w_fc < FC_W'(FC_CLAY_LIMIT)) ? KIND_CLAY : KIND_PEAT;
        end else if (w_y_scaled > w_hi_line) begin
            o_kind = KIND_SAND;
        end else begin
            o_kind = KIND_CLAY;
        end
        if (CFG_W'(w_fc) > i_peat_ratio_limit) begin
            o_kind = KIND_PEAT;
        end
    end

endmodule

@@ rtl/core/cslc_regs.sv @@
// APB configuration registers of the soil layer classifier.
module cslc_regs import cslc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ground_top       <= '0;
            r_cfg.excavated_depth  <= '0;
            r_cfg.min_layer_height <= MIN_LAYER_RESET;
            r_cfg.peat_ratio_limit <= PEAT_LIMIT_RESET;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_GROUND_TOP:       r_cfg.ground_top       <= pwdata[DEPTH_W-1:0];
                REG_EXCAVATED_DEPTH:  r_cfg.excavated_depth  <= pwdata[CFG_W-1:0];
                REG_MIN_LAYER_HEIGHT: r_cfg.min_layer_height <= pwdata[CFG_W-1:0];
                REG_PEAT_RATIO_LIMIT: r_cfg.peat_ratio_limit <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_GROUND_TOP:       prdata = DATA_W'($signed(r_cfg.ground_top));
            REG_EXCAVATED_DEPTH:  prdata = DATA_W'(r_cfg.excavated_depth);
            REG_MIN_LAYER_HEIGHT: prdata = DATA_W'(r_cfg.min_layer_height);
            REG_PEAT_RATIO_LIMIT: prdata = DATA_W'(r_cfg.peat_ratio_limit);
            default:              prdata = '0;
        endcase
    end

endmodule

@@ rtl/core/cslc_fifo.sv @@
// Result queue taking up to two layers per cycle; one leaves per ready cycle.
module cslc_fifo import cslc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_push i_push,
    output logic  o_room,
    cslc_lyr_if.source o_lyr
);

    t_layer             r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [FIFO_AW:0]   r_count;
    logic [FIFO_AW:0]   n_count;
    logic               w_pop;
    t_layer             w_head;

    assign w_pop   = o_lyr.valid & o_lyr.ready;
    assign o_room  = r_count <= (FIFO_AW + 1)'(FIFO_DEPTH - 2);
    assign n_count = r_count + (FIFO_AW + 1)'(i_push.count) - (FIFO_AW + 1)'(w_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + FIFO_AW'(i_push.count);
            r_rd_ptr <= r_rd_ptr + FIFO_AW'(w_pop);
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_mem[r_wr_ptr + FIFO_AW'(1)] <= i_push.second;
        end
    end

    assign w_head             = r_mem[r_rd_ptr];
    assign o_lyr.valid        = r_count != '0;
    assign o_lyr.layer_kind   = w_head.kind;
    assign o_lyr.layer_top    = w_head.top;
    assign o_lyr.layer_bottom = w_head.bottom;
    assign o_lyr.final_layer  = w_head.final_layer;

endmodule

@@ rtl/core/cslc_layer.sv @@
// Sample register, per-test window state and layer formation of the classifier.
module cslc_layer import cslc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    input  logic  i_room,
    output t_push o_push,
    cslc_smp_if.sink i_smp
);

    logic                      r_in_valid;
    logic signed [DEPTH_W-1:0] r_depth;
    logic        [QC_W-1:0]    r_q;
    logic signed [FR_W-1:0]    r_fr;
    logic                      r_last;

    logic                   r_started,    n_started;
    logic [COUNT_WIDTH-1:0] r_sand,       n_sand;
    logic [COUNT_WIDTH-1:0] r_clay,       n_clay;
    logic [COUNT_WIDTH-1:0] r_peat,       n_peat;
    logic signed [LVL_W-1:0] r_window_top, n_window_top;
    logic                   r_pv,         n_pv;
    t_kind                  r_pk,         n_pk;
    logic [DEPTH_W-1:0]     r_ptop,       n_ptop;
    logic [DEPTH_W-1:0]     r_pbot,       n_pbot;

    logic                    w_process;
    logic signed [LVL_W-1:0] w_exc_level;
    logic signed [LVL_W-1:0] w_depth_ext;
    logic signed [LVL_W:0]   w_close_lvl;
    t_kind                   w_chart_kind;
    t_kind                   w_kind;
    t_kind                   w_maj;
    logic                    w_emit0;
    logic                    w_emit1;
    t_layer                  w_layer0;
    t_layer                  w_layer1;

    assign w_process   = r_in_valid & i_room;
    assign i_smp.ready = !r_in_valid | i_room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_smp.ready) begin
            r_in_valid <= i_smp.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_smp.valid && i_smp.ready) begin
            r_depth <= i_smp.depth;
            r_q     <= i_smp.cone_resistance;
            r_fr    <= i_smp.friction_ratio;
            r_last  <= i_smp.last_sample;
        end
    end

    cslc_classify u_classify (
        .i_cone_resistance  (r_q),
        .i_friction_ratio   (r_fr),
        .i_peat_ratio_limit (i_cfg.peat_ratio_limit),
        .o_kind             (w_chart_kind)
    );

    assign w_exc_level = LVL_W'($signed(i_cfg.ground_top))
                       - $signed(LVL_W'(i_cfg.excavated_depth));
    assign w_depth_ext = LVL_W'(r_depth);
    assign w_kind      = (w_depth_ext < w_exc_level) ? w_chart_kind : KIND_EXC;

    always_comb begin
        n_started    = 1'b1;
        n_sand       = r_sand;
        n_clay       = r_clay;
        n_peat       = r_peat;
        n_window_top = r_window_top;
        n_pv         = r_pv;
        n_pk         = r_pk;
        n_ptop       = r_ptop;
        n_pbot       = r_pbot;
        w_emit0      = 1'b0;
        w_emit1      = 1'b0;
        w_layer0     = '0;
        w_layer1     = '0;
        w_maj        = KIND_SAND;
        w_close_lvl  = '0;

        if (!r_started) begin
            n_window_top = w_exc_level;
            n_sand       = '0;
            n_clay       = '0;
            n_peat       = '0;
            n_pv         = 1'b0;
            if (i_cfg.excavated_depth != '0) begin
                n_pv   = 1'b1;
                n_pk   = KIND_EXC;
                n_ptop = i_cfg.ground_top;
                n_pbot = w_exc_level[DEPTH_W-1:0];
            end
        end

        case (w_kind)
            KIND_SAND: if (n_sand != '1) n_sand = n_sand + COUNT_WIDTH'(1);
            KIND_CLAY: if (n_clay != '1) n_clay = n_clay + COUNT_WIDTH'(1);
            default:   if (n_peat != '1) n_peat = n_peat + COUNT_WIDTH'(1);
        endcase

        if (n_clay > n_peat && n_clay > n_sand) begin
            w_maj = KIND_CLAY;
        end else if (n_peat > n_clay && n_peat > n_sand) begin
            w_maj = KIND_PEAT;
        end

        w_close_lvl = (LVL_W + 1)'(n_window_top)
                    - $signed((LVL_W + 1)'(i_cfg.min_layer_height));

        if ((LVL_W + 1)'(w_depth_ext) < w_close_lvl) begin
            if (n_pv && n_pk == w_maj) begin
                n_pbot = r_depth;
            end else begin
                w_emit0  = n_pv;
                w_layer0 = '{kind: n_pk, top: n_ptop, bottom: n_pbot, final_layer: 1'b0};
                n_pv     = 1'b1;
                n_pk     = w_maj;
                n_ptop   = n_window_top[DEPTH_W-1:0];
                n_pbot   = r_depth;
            end
            n_sand       = '0;
            n_clay       = '0;
            n_peat       = '0;
            n_window_top = w_depth_ext;
        end

        if (r_last) begin
            w_emit1      = n_pv;
            w_layer1     = '{kind: n_pk, top: n_ptop, bottom: n_pbot, final_layer: 1'b1};
            n_started    = 1'b0;
            n_pv         = 1'b0;
            n_pk         = KIND_EXC;
            n_sand       = '0;
            n_clay       = '0;
            n_peat       = '0;
            n_window_top = '0;
            n_ptop       = '0;
            n_pbot       = '0;
        end
    end

    always_comb begin
        o_push.count  = 2'd0;
        o_push.first  = w_emit0 ? w_layer0 : w_layer1;
        o_push.second = w_layer1;
        if (w_process) begin
            o_push.count = 2'(w_emit0) + 2'(w_emit1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started    <= 1'b0;
            r_sand       <= '0;
            r_clay       <= '0;
            r_peat       <= '0;
            r_window_top <= '0;
            r_pv         <= 1'b0;
            r_pk         <= KIND_EXC;
            r_ptop       <= '0;
            r_pbot       <= '0;
        end else if (w_process) begin
            r_started    <= n_started;
            r_sand       <= n_sand;
            r_clay       <= n_clay;
            r_peat       <= n_peat;
            r_window_top <= n_window_top;
            r_pv         <= n_pv;
            r_pk         <= n_pk;
            r_ptop       <= n_ptop;
            r_pbot       <= n_pbot;
        end
    end

endmodule

@@ rtl/core/cslc_chk.sv @@
// Port-level assertion checker of the soil layer classifier and its bind.
module cslc_chk import cslc_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_smp_ready,
    input logic               o_lyr_valid,
    input logic               o_lyr_ready,
    input logic [1:0]         o_lyr_kind,
    input logic [DEPTH_W-1:0] o_lyr_top,
    input logic [DEPTH_W-1:0] o_lyr_bottom,
    input logic               o_lyr_final
);

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_lyr_valid)
        else $error("layer output valid after reset");

    a_reset_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> i_smp_ready)
        else $error("sample input not ready after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_lyr_valid && !o_lyr_ready |=> o_lyr_valid && $stable(o_lyr_kind)
            && $stable(o_lyr_top) && $stable(o_lyr_bottom) && $stable(o_lyr_final))
        else $error("stalled layer changed");

    // A non-final layer is only emitted when a layer of another kind replaces it.
    a_kind_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_lyr_valid && o_lyr_ready && !o_lyr_final) ##1 (o_lyr_valid && o_lyr_ready)
            |-> o_lyr_kind != $past(o_lyr_kind))
        else $error("consecutive layers of the same kind");

endmodule

bind cpt_soil_layer_classifier cslc_chk u_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_smp_ready  (i_smp.ready),
    .o_lyr_valid  (o_lyr.valid),
    .o_lyr_ready  (o_lyr.ready),
    .o_lyr_kind   (o_lyr.layer_kind),
    .o_lyr_top    (o_lyr.layer_top),
    .o_lyr_bottom (o_lyr.layer_bottom),
    .o_lyr_final  (o_lyr.final_layer)
);

@@ tb/sv/tb_cpt_soil_layer_classifier.sv @@
// Self-checking testbench of the cone-test soil layer classifier with its own layer predictor.
`timescale 1ns / 100ps

module tb_cpt_soil_layer_classifier;
    import cslc_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int LEVEL_MAX      = 100000;

    typedef struct {
        logic signed [DEPTH_W-1:0] depth;
        logic        [QC_W-1:0]    qc;
        logic signed [FR_W-1:0]    fr;
        logic                      last;
    } sample_t;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    cslc_smp_if smp ();
    cslc_lyr_if lyr ();

    cpt_soil_layer_classifier dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_smp   (smp),
        .o_lyr   (lyr)
    );

    sample_t sample_queue[$];
    t_layer  expected_layers[$];
    sample_t current_sample;
    int      samples_queued   = 0;
    int      samples_accepted = 0;
    int      error_count      = 0;
    int      send_idle_pct    = 0;
    int      recv_stall_pct   = 0;
    int      quiet_cycles     = 0;

    // Register copies used by the predictor.
    logic signed [DEPTH_W-1:0] cfg_ground_top = '0;
    logic        [CFG_W-1:0]   cfg_excavated  = '0;
    logic        [CFG_W-1:0]   cfg_min_layer  = MIN_LAYER_RESET;
    logic        [CFG_W-1:0]   cfg_peat_limit = PEAT_LIMIT_RESET;

    // Test state of the predictor.
    bit                     test_started = 1'b0;
    logic [COUNT_WIDTH-1:0] cnt_sand     = '0;
    logic [COUNT_WIDTH-1:0] cnt_clay     = '0;
    logic [COUNT_WIDTH-1:0] cnt_peat     = '0;
    int                     window_top   = 0;
    bit                     held_valid   = 1'b0;
    t_kind                  held_kind    = KIND_EXC;
    int                     held_top     = 0;
    int                     held_bottom  = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic t_kind soil_kind(logic [QC_W-1:0] q, logic signed [FR_W-1:0] fr);
        longint one;
        longint fc;
        longint y;
        longint l2;
        t_kind  k;
        one = longint'(1) << LOG_TABLE_BITS;
        if (fr < 0) begin
            fc = 0;
        end else if (fr > FC_MAX) begin
            fc = FC_MAX;
        end else begin
            fc = fr;
        end
        l2 = longint'(LOG10_Q14[2] >> LOG_SHIFT);
        if (q == '0) begin
            y = -one;
        end else if (q >= LOG_TABLE_SIZE) begin
            y = 2 * one;
        end else begin
            y = longint'(LOG10_Q14[q] >> LOG_SHIFT);
        end
        if (CHART_SCALE * y <= (fc - FC_MID) * one) begin
            k = (fc < FC_CLAY_LIMIT) ? KIND_CLAY : KIND_PEAT;
        end else if (CHART_SCALE * y > fc * one - CHART_SCALE * l2) begin
            k = KIND_SAND;
        end else begin
            k = KIND_CLAY;
        end
        if (fc > longint'(cfg_peat_limit)) begin
            k = KIND_PEAT;
        end
        return k;
    endfunction

    function automatic void store_layer(t_kind k, int top, int bottom, logic fin);
        t_layer l;
        l.kind        = k;
        l.top         = top[DEPTH_W-1:0];
        l.bottom      = bottom[DEPTH_W-1:0];
        l.final_layer = fin;
        expected_layers.push_back(l);
    endfunction

    function automatic void predict_layers(sample_t s);
        int    exc_level;
        int    level;
        t_kind kind;
        t_kind maj;
        exc_level = int'(cfg_ground_top) - int'(cfg_excavated);
        level     = int'(s.depth);
        if (!test_started) begin
            test_started = 1'b1;
            window_top   = exc_level;
            cnt_sand     = '0;
            cnt_clay     = '0;
            cnt_peat     = '0;
            held_valid   = 1'b0;
            if (cfg_excavated != '0) begin
                held_valid  = 1'b1;
                held_kind   = KIND_EXC;
                held_top    = int'(cfg_ground_top);
                held_bottom = exc_level;
            end
        end
        kind = (level < exc_level) ? soil_kind(s.qc, s.fr) : KIND_EXC;
        case (kind)
            KIND_SAND: if (cnt_sand != '1) cnt_sand++;
            KIND_CLAY: if (cnt_clay != '1) cnt_clay++;
            default:   if (cnt_peat != '1) cnt_peat++;
        endcase
        if (level < window_top - int'(cfg_min_layer)) begin
            if (cnt_clay > cnt_peat && cnt_clay > cnt_sand) begin
                maj = KIND_CLAY;
            end else if (cnt_peat > cnt_clay && cnt_peat > cnt_sand) begin
                maj = KIND_PEAT;
            end else begin
                maj = KIND_SAND;
            end
            if (held_valid && held_kind == maj) begin
                held_bottom = level;
            end else begin
                if (held_valid) store_layer(held_kind, held_top, held_bottom, 1'b0);
                held_valid  = 1'b1;
                held_kind   = maj;
                held_top    = window_top;
                held_bottom = level;
            end
            cnt_sand   = '0;
            cnt_clay   = '0;
            cnt_peat   = '0;
            window_top = level;
        end
        if (s.last) begin
            if (held_valid) store_layer(held_kind, held_top, held_bottom, 1'b1);
            test_started = 1'b0;
            held_valid   = 1'b0;
            held_kind    = KIND_EXC;
            held_top     = 0;
            held_bottom  = 0;
            window_top   = 0;
            cnt_sand     = '0;
            cnt_clay     = '0;
            cnt_peat     = '0;
        end
    endfunction

    // Sample driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            smp.valid <= 1'b0;
        end else begin
            if (smp.valid && smp.ready) begin
                predict_layers(current_sample);
                samples_accepted++;
            end
            if (!smp.valid || smp.ready) begin
                if (sample_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    current_sample        = sample_queue.pop_front();
                    smp.valid            <= 1'b1;
                    smp.depth            <= current_sample.depth;
                    smp.cone_resistance  <= current_sample.qc;
                    smp.friction_ratio   <= current_sample.fr;
                    smp.last_sample      <= current_sample.last;
                end else begin
                    smp.valid <= 1'b0;
                end
            end
        end
    end

    // Layer monitor.
    always @(posedge i_clk) begin
        t_layer want;
        if (!i_rst_n) begin
            lyr.ready <= 1'b0;
        end else begin
            if (lyr.valid && lyr.ready) begin
                if (expected_layers.size() == 0) begin
                    error_count++;
                    $display({"%0t: layer mismatch: expected no layer, got kind %0d ",
                              "top %0d bottom %0d final %0d"},
                             $time, lyr.layer_kind, lyr.layer_top, lyr.layer_bottom,
                             lyr.final_layer);
                end else begin
                    want = expected_layers.pop_front();
                    if (lyr.layer_kind !== want.kind || lyr.layer_top !== want.top ||
                        lyr.layer_bottom !== want.bottom ||
                        lyr.final_layer !== want.final_layer) begin
                        error_count++;
                        $display({"%0t: layer mismatch: expected kind %0d top %0d ",
                                  "bottom %0d final %0d, got kind %0d top %0d ",
                                  "bottom %0d final %0d"},
                                 $time, want.kind, $signed(want.top),
                                 $signed(want.bottom), want.final_layer,
                                 lyr.layer_kind, lyr.layer_top, lyr.layer_bottom,
                                 lyr.final_layer);
                    end
                end
            end
            lyr.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((smp.valid && smp.ready) || (lyr.valid && lyr.ready) || psel) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic apb_write(t_reg_idx idx, logic [DATA_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_config(int ground, int exc, int min_h, int peat);
        apb_write(REG_GROUND_TOP, ground);
        apb_write(REG_EXCAVATED_DEPTH, exc);
        apb_write(REG_MIN_LAYER_HEIGHT, min_h);
        apb_write(REG_PEAT_RATIO_LIMIT, peat);
        cfg_ground_top = ground[DEPTH_W-1:0];
        cfg_excavated  = exc[CFG_W-1:0];
        cfg_min_layer  = min_h[CFG_W-1:0];
        cfg_peat_limit = peat[CFG_W-1:0];
    endtask

    task automatic add_sample(int depth, int qc, int fr, bit last);
        sample_t s;
        s.depth = depth[DEPTH_W-1:0];
        s.qc    = qc[QC_W-1:0];
        s.fr    = fr[FR_W-1:0];
        s.last  = last;
        sample_queue.push_back(s);
        samples_queued++;
    endtask

    function automatic int clamp_level(int v);
        if (v > LEVEL_MAX) return LEVEL_MAX;
        if (v < -LEVEL_MAX) return -LEVEL_MAX;
        return v;
    endfunction

    function automatic int rand_qc(int cls);
        case (cls)
            0:       return 0;
            1:       return $urandom_range(99, 1);
            default: return $urandom_range(100000, 100);
        endcase
    endfunction

    function automatic int rand_fr(int cls);
        case (cls)
            0:       return -int'($urandom_range(2000, 1));
            1:       return $urandom_range(1000, 0);
            default: return $urandom_range(10000, 1001);
        endcase
    endfunction

    // One cone test of falling depth through zones of similar soil, with a few rises.
    task automatic add_random_test(int step_max, bit close_it);
        int depth;
        int n;
        int i;
        int q_cls;
        int fr_cls;
        int r;
        n     = $urandom_range(12, 1);
        depth = clamp_level(int'(cfg_ground_top) + int'($urandom_range(20)) - 5);
        q_cls = 1;
        fr_cls = 1;
        for (i = 0; i < n; i++) begin
            if (i == 0 || $urandom_range(3) == 0) begin
                q_cls  = ($urandom_range(7) == 0) ? 0 : $urandom_range(2, 1);
                r      = $urandom_range(7);
                fr_cls = (r == 0) ? 0 : ((r == 7) ? 2 : 1);
            end
            add_sample(depth, rand_qc(q_cls), rand_fr(fr_cls), close_it && i == n - 1);
            if ($urandom_range(15) == 0) begin
                depth = clamp_level(depth + int'($urandom_range(step_max)));
            end else begin
                depth = clamp_level(depth - int'($urandom_range(step_max, 1)));
            end
        end
    endtask

    task automatic drain_results();
        while (samples_accepted != samples_queued || expected_layers.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int phase;
        int step_max;
        int start_count;
        i_rst_n             = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed tests under the reset register values.
        send_idle_pct  = 37;
        recv_stall_pct = 37;
        add_sample(0, 0, -2000, 0);
        add_sample(-10, 1, 0, 0);
        add_sample(-25, 99, 399, 0);
        add_sample(-30, 100, 400, 0);
        add_sample(-50, 100000, 1000, 0);
        add_sample(-60, 50, 10000, 0);
        add_sample(-75, 5, 700, 0);
        add_sample(-90, 2, 600, 0);
        add_sample(-100, 3, 450, 1);
        add_sample(0, 10, 200, 1);
        add_sample(100000, 100000, 10000, 0);
        add_sample(-100000, 0, -2000, 1);
        add_sample(0, 20, 100, 0);
        add_sample(-30, 20, 100, 0);
        add_sample(-40, 20, 100, 1);
        drain_results();

        // Excavated layer at the low end of the level range, reaching below it.
        write_config(-100000, 10000, 10000, 0);
        add_sample(-100000, 50, 500, 0);
        add_sample(-100000, 0, 0, 1);
        drain_results();

        // Top of the level range, every sample after the first closing a window, peat forced by ratio.
        write_config(100000, 0, 0, 0);
        add_sample(100000, 100000, 0, 0);
        add_sample(99990, 100000, 0, 0);
        add_sample(99980, 30, 800, 0);
        add_sample(99970, 30, 0, 0);
        add_sample(99960, 30, 0, 1);
        drain_results();

        for (phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin
                    write_config(0, 0, 20, 10000);
                    step_max = 15;
                end
                1: begin
                    write_config(int'($urandom_range(2000)) - 1000, $urandom_range(50),
                                 $urandom_range(60, 5), $urandom_range(1200, 300));
                    step_max = 20;
                end
                2: begin
                    write_config(int'($urandom_range(200000)) - 100000, 0, 0, 10000);
                    step_max = 10;
                end
                3: begin
                    write_config(int'($urandom_range(200000)) - 100000, $urandom_range(10000),
                                 10000, $urandom_range(10000));
                    step_max = 3000;
                end
                default: begin
                    write_config(int'($urandom_range(200000)) - 100000,
                                 ($urandom_range(3) == 0) ? $urandom_range(10000)
                                                          : $urandom_range(200),
                                 $urandom_range(100),
                                 ($urandom_range(2) == 0) ? $urandom_range(10000) : 10000);
                    step_max = 30;
                end
            endcase
            case (phase % 4)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 46;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 46;
                end
                default: begin
                    send_idle_pct  = 37;
                    recv_stall_pct = 37;
                end
            endcase
            start_count = samples_queued;
            while (samples_queued - start_count < 20) begin
                add_random_test(step_max, $urandom_range(3) != 0);
            end
            drain_results();
        end

        if (error_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
